FILE: rtl/mcfsm_pkg.sv
// shared types and constants of the frame slot manager
package mcfsm_pkg;
  localparam int CHANNELS_DEF = 4;
  localparam int SLOTS_DEF = 8;
  localparam logic [3:0] SLOTS_RESET = 4'd5;

  localparam logic [2:0] CMD_OPEN = 3'd0;
  localparam logic [2:0] CMD_CLOSE = 3'd1;
  localparam logic [2:0] CMD_SEND = 3'd2;
  localparam logic [2:0] CMD_GET = 3'd3;
  localparam logic [2:0] CMD_RELEASE = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_CLOSED = 3'd3;
  localparam logic [2:0] ST_NOFREE = 3'd4;

  localparam logic CFG_SLOTS = 1'b0;
  localparam logic CFG_HOLD = 1'b1;

  // classified command word handed from front to back
  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  channel;
    logic        ch_ok;
    logic [15:0] frame_len;
    logic [31:0] frame_seq;
  } cmd_word_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WRITE, S_NEXTCH, S_DONE
  } back_state_t;
endpackage

FILE: rtl/mcfsm_front.sv
// command front end: takes words, classifies them, two-entry queue
module mcfsm_front #(
  parameter int CHANNELS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             in_cmd,
  input  logic [1:0]             in_channel,
  input  logic [15:0]            in_frame_len,
  input  logic [31:0]            in_frame_seq,
  input  logic [CHANNELS-1:0]    ch_open,
  input  logic                   back_idle,
  input  logic                   done,
  output logic                   q_valid,
  output mcfsm_pkg::cmd_word_t   q_word,
  input  logic                   q_pop
);
  import mcfsm_pkg::*;
  logic [1:0] cnt_r, cnt_nxt;
  logic pend_r, pend_nxt;
  cmd_word_t slot_r [2];
  logic rd_r, wr_r;
  cmd_word_t w;
  logic take;

  // one command outstanding at a time, so the channel test sees fresh state
  assign busy = pend_r;
  assign take = start && !busy;

  always_comb begin
    w.cmd = in_cmd;
    w.channel = 4'(in_channel);
    w.ch_ok = (32'(in_channel) < CHANNELS) &&
              ch_open[(32'(in_channel) < CHANNELS) ? in_channel : 2'd0];
    w.frame_len = in_frame_len;
    w.frame_seq = in_frame_seq;
  end

  assign q_valid = cnt_r != 2'd0 && back_idle;
  assign q_word = slot_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(take) - 2'(q_pop);
    pend_nxt = pend_r;
    if (take) pend_nxt = 1'b1;
    else if (done) pend_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pend_r <= 1'b0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      pend_r <= pend_nxt;
      if (take) wr_r <= !wr_r;
      if (q_pop) rd_r <= !rd_r;
    end
    if (take) slot_r[wr_r] <= w;
  end
endmodule

FILE: rtl/mcfsm_back.sv
// command back end: slot state and sequencer scanning one slot a cycle
module mcfsm_back #(
  parameter int CHANNELS = 4,
  parameter int SLOTS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [3:0]            slots_in_use,
  input  logic                  hold_mode,
  input  logic                  q_valid,
  input  mcfsm_pkg::cmd_word_t  q_word,
  output logic                  q_pop,
  output logic                  back_idle,
  output logic [CHANNELS-1:0]   ch_open,
  output logic                  done,
  output logic [2:0]            status,
  output logic [1:0]            channel_id,
  output logic [15:0]           out_len,
  output logic [31:0]           out_seq
);
  import mcfsm_pkg::*;
  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW = $clog2(SLOTS + 1);

  back_state_t st_r, st_nxt;
  cmd_word_t cw_r;
  logic [CHANNELS-1:0] open_r;
  logic [SW-1:0] next_r [CHANNELS];
  logic [31:0] wcnt_r [CHANNELS];
  logic [SLOTS-1:0] wr_r [CHANNELS];
  logic [SLOTS-1:0] held_r [CHANNELS];
  logic [31:0] seq_r [CHANNELS][SLOTS];
  logic [15:0] len_r [CHANNELS][SLOTS];

  logic [CW-1:0] ch_r;
  logic [SW-1:0] pos_r;
  logic [CNTW-1:0] j_r;
  logic found_r;
  logic [SW-1:0] best_r;
  logic [31:0] bage_r;
  logic [2:0] stat_r;
  logic [1:0] cid_r;
  logic done_r;
  logic [15:0] olen_r;
  logic [31:0] oseq_r;

  logic [CNTW-1:0] n;
  logic [CW-1:0] cc;
  logic [SW-1:0] pw;
  logic [31:0] age;
  logic last_j;
  logic fa_found;
  logic [CW-1:0] fa_idx;
  logic [CW-1:0] nxt_open;
  logic has_nxt;

  always_comb begin
    if (slots_in_use == 4'd0) n = CNTW'(1);
    else if (32'(slots_in_use) > SLOTS) n = CNTW'(SLOTS);
    else n = CNTW'(slots_in_use);
  end

  assign cc = (cw_r.cmd == CMD_SEND) ? ch_r : cw_r.channel[CW-1:0];
  assign pw = (32'(pos_r) >= 32'(n)) ? '0 : pos_r;
  assign age = wcnt_r[cc] - seq_r[cc][pos_r];
  assign last_j = (32'(j_r) + 1 >= 32'(n));
  assign ch_open = open_r;
  assign back_idle = (st_r == S_IDLE);
  assign q_pop = q_valid && back_idle;

  // first closed channel, and next open channel after ch_r
  always_comb begin
    fa_found = 1'b0;
    fa_idx = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (!open_r[c]) begin
        fa_found = 1'b1;
        fa_idx = CW'(c);
      end
    end
  end
  always_comb begin
    has_nxt = 1'b0;
    nxt_open = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (open_r[c] && 32'(c) > 32'(ch_r)) begin
        has_nxt = 1'b1;
        nxt_open = CW'(c);
      end
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_pop) st_nxt = S_SCAN;
      S_SCAN: begin
        case (cw_r.cmd)
          CMD_SEND: begin
            if (!open_r[ch_r]) st_nxt = S_NEXTCH;
            else if (!held_r[ch_r][pw]) st_nxt = S_WRITE;
            else if (last_j) st_nxt = S_DONE;
          end
          CMD_GET, CMD_RELEASE: if (!cw_r.ch_ok || last_j) st_nxt = S_DONE;
          default: st_nxt = S_DONE;
        endcase
      end
      S_WRITE: st_nxt = S_NEXTCH;
      S_NEXTCH: st_nxt = has_nxt ? S_SCAN : S_DONE;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign done = done_r;
  assign status = stat_r;
  assign channel_id = cid_r;
  assign out_len = olen_r;
  assign out_seq = oseq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      open_r <= '0;
      done_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        wr_r[c] <= '0;
        held_r[c] <= '0;
        next_r[c] <= '0;
        wcnt_r[c] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      done_r <= (st_r == S_DONE);
      case (st_r)
        S_IDLE: if (q_pop) begin
          cw_r <= q_word;
          ch_r <= '0;
          pos_r <= (q_word.cmd == CMD_SEND) ? next_r[0] : '0;
          j_r <= '0;
          found_r <= 1'b0;
          bage_r <= '0;
          best_r <= '0;
          stat_r <= ST_OK;
          cid_r <= '0;
          olen_r <= '0;
          oseq_r <= '0;
        end
        S_SCAN: begin
          case (cw_r.cmd)
            CMD_OPEN: begin
              if (fa_found) begin
                open_r[fa_idx] <= 1'b1;
                wr_r[fa_idx] <= '0;
                held_r[fa_idx] <= '0;
                next_r[fa_idx] <= '0;
                wcnt_r[fa_idx] <= '0;
                cid_r <= 2'(fa_idx);
              end else stat_r <= ST_NOFREE;
            end
            CMD_CLOSE: if (32'(cw_r.channel) < CHANNELS) open_r[cw_r.channel[CW-1:0]] <= 1'b0;
            CMD_SEND: if (open_r[ch_r]) begin
              pos_r <= pw;
              if (held_r[ch_r][pw]) begin
                pos_r <= pw + SW'(1);
                j_r <= j_r + CNTW'(1);
                if (last_j) begin
                  stat_r <= ST_FULL;
                  cid_r <= 2'(ch_r);
                end
              end
            end
            CMD_GET: begin
              if (!cw_r.ch_ok) stat_r <= ST_CLOSED;
              else begin
                if (wr_r[cc][pos_r] && !held_r[cc][pos_r] &&
                    (!found_r || age > bage_r)) begin
                  found_r <= 1'b1;
                  best_r <= pos_r;
                  bage_r <= age;
                end
                pos_r <= pos_r + SW'(1);
                j_r <= j_r + CNTW'(1);
              end
            end
            CMD_RELEASE: begin
              if (!cw_r.ch_ok) stat_r <= ST_CLOSED;
              else begin
                if (!found_r && held_r[cc][pos_r] && len_r[cc][pos_r] == cw_r.frame_len &&
                    seq_r[cc][pos_r] == cw_r.frame_seq) begin
                  found_r <= 1'b1;
                  held_r[cc][pos_r] <= 1'b0;
                  wr_r[cc][pos_r] <= 1'b0;
                end
                pos_r <= pos_r + SW'(1);
                j_r <= j_r + CNTW'(1);
              end
            end
            default: ;
          endcase
          if (cw_r.cmd == CMD_GET || cw_r.cmd == CMD_RELEASE) begin
            if (j_r == '0) pos_r <= SW'(1);
          end
        end
        S_WRITE: begin
          wcnt_r[ch_r] <= wcnt_r[ch_r] + 32'd1;
          wr_r[ch_r][pos_r] <= 1'b1;
          seq_r[ch_r][pos_r] <= wcnt_r[ch_r] + 32'd1;
          len_r[ch_r][pos_r] <= cw_r.frame_len;
          next_r[ch_r] <= pos_r + SW'(1);
        end
        S_NEXTCH: begin
          ch_r <= nxt_open;
          pos_r <= next_r[nxt_open];
          j_r <= '0;
        end
        S_DONE: begin
          if (cw_r.cmd == CMD_GET && cw_r.ch_ok && stat_r == ST_OK) begin
            if (!found_r) stat_r <= ST_EMPTY;
            else begin
              olen_r <= len_r[cc][best_r];
              oseq_r <= seq_r[cc][best_r];
              if (hold_mode) held_r[cc][best_r] <= 1'b1;
              else wr_r[cc][best_r] <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: rtl/multi_channel_frame_slot_manager_core.sv
// top level of the multi-channel frame slot manager
//  channel | handshake          | words
//  in_     | start & !busy      | in_cmd, in_channel, in_frame_len, in_frame_seq
//  out_    | out_strobe, 1 cyc  | out_status, out_channel_id, out_len, out_seq
//  cfg_    | cfg_valid & ready  | cfg_index, cfg_data
// a word passes the front queue, then S_SCAN and S_DONE for open/close; get/release
// scan the n slots in S_SCAN; send scans each open channel from its next slot in
// S_SCAN, then S_WRITE and S_NEXTCH; n is the clamped slots_in_use, and the back
// end scans one slot a cycle. busy stays high through the result strobe; reset is
// synchronous on rst_n and clears all flags; the receiver cannot stall, so results never wait
module multi_channel_frame_slot_manager_core
  import mcfsm_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF,
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [1:0]  in_channel,
  input  logic [15:0] in_frame_len,
  input  logic [31:0] in_frame_seq,
  output logic        out_strobe,
  output logic [2:0]  out_status,
  output logic [1:0]  out_channel_id,
  output logic [15:0] out_len,
  output logic [31:0] out_seq,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);
  logic [3:0] slots_r;
  logic hold_r;
  logic [CHANNELS-1:0] ch_open;
  logic back_idle, q_valid, q_pop, done;
  cmd_word_t q_word;

  // config is always taken; the user must write it only while idle, the block does not enforce this
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= SLOTS_RESET;
      hold_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SLOTS: slots_r <= cfg_data;
        CFG_HOLD: hold_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  mcfsm_front #(.CHANNELS(CHANNELS)) u_front (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_channel, .in_frame_len, .in_frame_seq,
    .ch_open, .back_idle, .done, .q_valid, .q_word, .q_pop
  );

  mcfsm_back #(.CHANNELS(CHANNELS), .SLOTS(SLOTS)) u_back (
    .clk, .rst_n, .slots_in_use(slots_r), .hold_mode(hold_r), .q_valid, .q_word,
    .q_pop, .back_idle, .ch_open, .done, .status(out_status),
    .channel_id(out_channel_id), .out_len, .out_seq
  );

  assign out_strobe = done;
endmodule
